>>> rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared result types and byte-class constants for the transcoder core.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

   localparam int MaxResults  = 3;
   localparam int QueueDepth  = 4;
   localparam int CountWidth  = $clog2(MaxResults + 1);
   localparam int LevelWidth  = $clog2(QueueDepth + 1);
   localparam int SlotWidth   = $clog2(QueueDepth);

   localparam logic [7:0]  LEAD_TWO_LIMIT   = 8'hE0;
   localparam logic [7:0]  LEAD_THREE_LIMIT = 8'hF0;
   localparam logic [7:0]  ASCII_LIMIT      = 8'h80;
   localparam logic [19:0] SUPP_OFFSET      = 20'h10000;
   localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_TRUNCATED = 1'b1;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_end;
      logic        status;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [CountWidth-1:0]        count;
      result_type [MaxResults-1:0]  item;
   } burst_type;

endpackage

`default_nettype wire

>>> rtl/core/u8u16_step.sv
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Holds the sequence state and turns one accepted byte into up to three
// result items combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_step
   import u8u16_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  byte_in,
   input  wire logic        final_byte,
   output burst_type        burst
);

   logic [1:0]  pending_ff, pending_in;
   logic [20:0] partial_ff, partial_in;
   logic        four_ff, four_in;
   logic        skip_ff, skip_in;

   always_comb begin
      logic [20:0] joined;
      logic [19:0] offset;
      logic [1:0]  left;
      logic        ended;
      result_type  res;

      pending_in = pending_ff;
      partial_in = partial_ff;
      four_in    = four_ff;
      skip_in    = skip_ff;
      burst      = '0;
      ended      = 1'b0;
      joined     = {partial_ff[14:0], byte_in[5:0]};
      offset     = joined[19:0] - SUPP_OFFSET;
      left       = pending_ff - 2'd1;
      res        = '0;

      if (skip_ff) begin
         if (final_byte) begin
            skip_in = 1'b0;
         end
      end else begin
         if (pending_ff != 2'd0) begin
            partial_in = joined;
            pending_in = left;
            if (left == 2'd0) begin
               if (four_ff) begin
                  res.code_unit = HIGH_SURR_BASE | {6'd0, offset[19:10]};
                  burst.item[0] = res;
                  res.code_unit = LOW_SURR_BASE | {6'd0, offset[9:0]};
                  burst.item[1] = res;
                  burst.count   = CountWidth'(2);
               end else begin
                  res.code_unit = joined[15:0];
                  burst.item[0] = res;
                  burst.count   = CountWidth'(1);
               end
               partial_in = '0;
               four_in    = 1'b0;
            end
         end else if (byte_in == 8'd0) begin
            res.is_end    = 1'b1;
            res.status    = STATUS_OK;
            burst.item[0] = res;
            burst.count   = CountWidth'(1);
            ended         = 1'b1;
            skip_in       = !final_byte;
         end else if (byte_in < ASCII_LIMIT) begin
            res.code_unit = {8'd0, byte_in};
            burst.item[0] = res;
            burst.count   = CountWidth'(1);
         end else if (byte_in < LEAD_TWO_LIMIT) begin
            partial_in = {16'd0, byte_in[4:0]};
            pending_in = 2'd1;
            four_in    = 1'b0;
         end else if (byte_in < LEAD_THREE_LIMIT) begin
            partial_in = {17'd0, byte_in[3:0]};
            pending_in = 2'd2;
            four_in    = 1'b0;
         end else begin
            partial_in = {18'd0, byte_in[2:0]};
            pending_in = 2'd3;
            four_in    = 1'b1;
         end

         // The end report of a final byte follows whatever the byte produced.
         if (final_byte) begin
            if (!ended) begin
               res           = '0;
               res.is_end    = 1'b1;
               res.status    = (pending_in != 2'd0) ? STATUS_TRUNCATED : STATUS_OK;
               burst.item[burst.count[1:0]] = res;
               burst.count   = burst.count + CountWidth'(1);
            end
            pending_in = '0;
            partial_in = '0;
            four_in    = 1'b0;
            skip_in    = 1'b0;
         end
      end

      if (burst.count != '0) begin
         burst.item[burst.count[1:0] - 2'd1].last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         partial_ff <= '0;
         four_ff    <= 1'b0;
         skip_ff    <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         four_ff    <= four_in;
         skip_ff    <= skip_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/utf8_to_utf16_transcoder.sv
// Results are registered in the result queue and offered on rsp_ from its head.
// Throughput: one byte per cycle while each byte gives at most one result and
// the result port is not stalled. The result port drains one item per cycle
// while rsp_ready is high. A four-entry result queue sets this.
// Reset: synchronous, active high; empties the queue and clears decode state.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a byte stream into UTF-16 code units and end-of-string reports.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder
   import u8u16_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_byte_in,
   input  wire logic        req_final_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [15:0] rsp_code_unit,
   output      logic        rsp_is_end,
   output      logic        rsp_status,
   output      logic        rsp_last_of_run
);

   result_type [QueueDepth-1:0] queue_ff, queue_in;
   logic [LevelWidth-1:0]       level_ff, level_in;
   logic                        req_fire, rsp_fire;
   burst_type                   burst;
   logic [SlotWidth-1:0]        tail_slot;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   // Accept only when a full burst of results is sure to fit.
   assign req_ready = level_ff <= LevelWidth'(QueueDepth - MaxResults);
   assign rsp_valid = level_ff != '0;

   assign rsp_code_unit   = queue_ff[0].code_unit;
   assign rsp_is_end      = queue_ff[0].is_end;
   assign rsp_status      = queue_ff[0].status;
   assign rsp_last_of_run = queue_ff[0].last_of_run;
   assign tail_slot       = SlotWidth'(level_ff - LevelWidth'(1));

   u8u16_step step_inst (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_fire),
      .byte_in    (req_byte_in),
      .final_byte (req_final_byte),
      .burst      (burst)
   );

   always_comb begin
      logic [LevelWidth-1:0] base;
      logic [LevelWidth-1:0] offset;
      logic [LevelWidth-1:0] pushed;

      base   = level_ff - LevelWidth'(rsp_fire);
      pushed = req_fire ? LevelWidth'(burst.count) : '0;
      for (int i = 0; i < QueueDepth; i++) begin
         if (rsp_fire && i < QueueDepth - 1) begin
            queue_in[i] = queue_ff[i+1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         offset = LevelWidth'(i) - base;
         if (LevelWidth'(i) >= base && offset < pushed) begin
            queue_in[i] = burst.item[offset[1:0]];
         end
      end
      level_in = base + pushed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
      queue_ff <= queue_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      level_ff <= LevelWidth'(QueueDepth))
      else $error("result queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !req_fire) |=> level_ff == $past(level_ff) - LevelWidth'(1))
      else $error("queue level lost track of a drained item");

   assert property (@(posedge clock) disable iff (reset)
      level_ff != '0 |-> queue_ff[tail_slot].last_of_run)
      else $error("queue tail is not the last item of a byte");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && burst.count > CountWidth'(1)) |->
         burst.item[0].is_end == 1'b0)
      else $error("end report placed before a code unit");

endmodule

`default_nettype wire

>>> test/tb_utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Feeds directed and random byte strings through the transcoder with bursty
// input and a stalling result side. Every byte accepted is decoded by a local
// model. The results it predicts are compared field by field, in order, with
// the items the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_utf8_to_utf16_transcoder;
   import u8u16_pkg::*;

   localparam int ClockPeriod  = 10;
   localparam int ResetCycles  = 12;
   localparam int ItemTarget   = 380;
   localparam int IdleLimit    = 2000;
   localparam int SettleCycles = 16;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain;
   } source_byte_type;

   typedef enum int {
      TAIL_FINAL_ON_LAST,
      TAIL_ZERO_THEN_JUNK,
      TAIL_ZERO_FINAL,
      TAIL_CUT_SEQUENCE
   } string_tail_type;

   typedef enum int {
      READY_ALWAYS,
      READY_CHOPPY,
      READY_SLOW
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_is_end;
   logic        rsp_status;
   logic        rsp_last_of_run;

   utf8_to_utf16_transcoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_is_end      (rsp_is_end),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   source_byte_type pending_bytes[$];
   result_type      expected_units[$];
   result_type      observed_units[$];

   int bytes_queued     = 0;
   int strings_queued   = 0;
   int bytes_accepted   = 0;
   int units_checked    = 0;
   int end_reports      = 0;
   int truncated_ends   = 0;
   int mismatch_count   = 0;
   int idle_cycles      = 0;

   // Decoder state of the local model.
   logic [1:0]  pend_cnt;
   logic [20:0] cp_bits;
   logic        in_four;
   logic        skip_tail;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   function automatic result_type make_unit(input logic [15:0] unit, input logic is_end,
                                            input logic status);
      result_type r;
      r.code_unit   = unit;
      r.is_end      = is_end;
      r.status      = status;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic clear_decoder();
      pend_cnt  = 2'd0;
      cp_bits   = 21'd0;
      in_four   = 1'b0;
      skip_tail = 1'b0;
   endtask

   // Decodes one accepted byte and appends the results it causes.
   task automatic predict_units(input logic [7:0] b, input logic fin);
      result_type  units[$];
      logic [19:0] supp;
      logic        ended;
      ended = 1'b0;
      if (skip_tail) begin
         if (fin)
            clear_decoder();
         return;
      end
      if (pend_cnt != 2'd0) begin
         cp_bits  = {cp_bits[14:0], b[5:0]};
         pend_cnt = pend_cnt - 2'd1;
         if (pend_cnt == 2'd0) begin
            if (in_four) begin
               // Values below the supplementary range wrap around here.
               supp = cp_bits[19:0] - SUPP_OFFSET;
               units.push_back(make_unit(HIGH_SURR_BASE | {6'd0, supp[19:10]}, 1'b0,
                                         STATUS_OK));
               units.push_back(make_unit(LOW_SURR_BASE | {6'd0, supp[9:0]}, 1'b0,
                                         STATUS_OK));
            end else begin
               units.push_back(make_unit(cp_bits[15:0], 1'b0, STATUS_OK));
            end
            cp_bits = 21'd0;
            in_four = 1'b0;
         end
      end else if (b == 8'h00) begin
         units.push_back(make_unit(16'h0000, 1'b1, STATUS_OK));
         ended = 1'b1;
         if (!fin)
            skip_tail = 1'b1;
      end else if (b < ASCII_LIMIT) begin
         units.push_back(make_unit({8'h00, b}, 1'b0, STATUS_OK));
      end else if (b < LEAD_TWO_LIMIT) begin
         cp_bits  = {16'd0, b[4:0]};
         pend_cnt = 2'd1;
         in_four  = 1'b0;
      end else if (b < LEAD_THREE_LIMIT) begin
         cp_bits  = {17'd0, b[3:0]};
         pend_cnt = 2'd2;
         in_four  = 1'b0;
      end else begin
         cp_bits  = {18'd0, b[2:0]};
         pend_cnt = 2'd3;
         in_four  = 1'b1;
      end
      if (fin) begin
         if (!ended)
            units.push_back(make_unit(16'h0000, 1'b1,
                                      pend_cnt != 2'd0 ? STATUS_TRUNCATED : STATUS_OK));
         clear_decoder();
      end
      if (units.size() != 0)
         units[units.size() - 1].last_of_run = 1'b1;
      foreach (units[i])
         expected_units.push_back(units[i]);
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic last, input logic drain);
      source_byte_type item;
      item.data  = data;
      item.last  = last;
      item.drain = drain;
      pending_bytes.push_back(item);
      bytes_queued++;
   endtask

   function automatic logic [7:0] random_lead(input int seq_len);
      case (seq_len)
         1: return 8'($urandom_range(8'h01, 8'h7F));
         2: return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'h80, 8'hC1))
                                              : 8'($urandom_range(8'hC2, 8'hDF));
         3: return 8'($urandom_range(8'hE0, 8'hEF));
         default: return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'hF8, 8'hFF))
                                                    : 8'($urandom_range(8'hF0, 8'hF7));
      endcase
   endfunction

   // Continuation bytes are mostly well formed; a few carry any value at all.
   function automatic logic [7:0] random_cont();
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   initial begin : build_stimulus
      logic [7:0]      str_bytes[$];
      string_tail_type tail;
      int              seq_len;
      int              pick;
      logic            drain;

      // ASCII extremes.
      queue_byte(8'h7F, 1'b0, 1'b0);
      queue_byte(8'h01, 1'b0, 1'b0);
      // A continuation byte used as a lead acts as a two-byte lead.
      queue_byte(8'h80, 1'b0, 1'b0);
      queue_byte(8'hBF, 1'b0, 1'b0);
      // A zero byte inside a sequence is just a continuation.
      queue_byte(8'hDF, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      // Three-byte value in the surrogate range passes through as is.
      queue_byte(8'hED, 1'b0, 1'b0);
      queue_byte(8'hA0, 1'b0, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b0);
      // Largest legal four-byte value.
      queue_byte(8'hF4, 1'b0, 1'b0);
      queue_byte(8'h8F, 1'b0, 1'b0);
      queue_byte(8'hBF, 1'b0, 1'b0);
      queue_byte(8'hBF, 1'b0, 1'b0);
      // Overlong four-byte value below the supplementary range.
      queue_byte(8'hF0, 1'b0, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b0);
      // Source ends inside a three-byte sequence.
      queue_byte(8'hE2, 1'b0, 1'b0);
      queue_byte(8'h82, 1'b1, 1'b0);
      // Final flag on a plain ASCII byte.
      queue_byte(8'h41, 1'b1, 1'b0);
      // Zero lead mid-string; the rest up to the final flag is dropped.
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_byte(8'h33, 1'b1, 1'b0);
      queue_byte(8'h00, 1'b1, 1'b0);
      queue_byte(8'hFF, 1'b1, 1'b0);
      strings_queued = 5;

      while (bytes_queued < ItemTarget) begin
         str_bytes.delete();
         strings_queued++;
         tail = TAIL_FINAL_ON_LAST;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10))
               str_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               seq_len = $urandom_range(1, 4);
               str_bytes.push_back(random_lead(seq_len));
               repeat (seq_len - 1)
                  str_bytes.push_back(random_cont());
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
               tail = TAIL_FINAL_ON_LAST;
            else if (pick < 65)
               tail = TAIL_ZERO_THEN_JUNK;
            else if (pick < 80)
               tail = TAIL_ZERO_FINAL;
            else
               tail = TAIL_CUT_SEQUENCE;
         end
         case (tail)
            TAIL_ZERO_THEN_JUNK: begin
               str_bytes.push_back(8'h00);
               repeat ($urandom_range(1, 5))
                  str_bytes.push_back(8'($urandom_range(0, 255)));
            end
            TAIL_ZERO_FINAL: str_bytes.push_back(8'h00);
            TAIL_CUT_SEQUENCE: begin
               seq_len = $urandom_range(2, 4);
               str_bytes.push_back(random_lead(seq_len));
               repeat ($urandom_range(0, seq_len - 2))
                  str_bytes.push_back(random_cont());
            end
            default: ;
         endcase
         drain = ($urandom_range(0, 24) == 0);
         foreach (str_bytes[i])
            queue_byte(str_bytes[i], i == str_bytes.size() - 1, drain && i == 0);
      end

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender: bursts of random length separated by random gaps. An item marked
   // for draining is held back until every predicted result has come out.
   int              burst_left = 0;
   int              gap_left   = 0;
   source_byte_type next_byte;

   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_byte_in    <= 8'h00;
         req_final_byte <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
         clear_decoder();
      end else begin
         if (req_valid && req_ready) begin
            predict_units(req_byte_in, req_final_byte);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() == 0 ||
                         (pending_bytes[0].drain && expected_units.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               next_byte = pending_bytes.pop_front();
               req_valid      <= 1'b1;
               req_byte_in    <= next_byte.data;
               req_final_byte <= next_byte.last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Receiver: stall behavior changes every so often between none, short
   // frequent stalls and long occasional ones.
   ready_mode_type stall_mode  = READY_ALWAYS;
   int             mode_cycles = 0;
   int             stall_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            observed_units.push_back({rsp_code_unit, rsp_is_end, rsp_status,
                                      rsp_last_of_run});
         mode_cycles++;
         if (mode_cycles == 150) begin
            mode_cycles = 0;
            stall_mode  = ready_mode_type'($urandom_range(0, 2));
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_mode == READY_CHOPPY && $urandom_range(0, 99) < 35) begin
            stall_left = $urandom_range(0, 1);
            rsp_ready <= 1'b0;
         end else if (stall_mode == READY_SLOW && $urandom_range(0, 99) < 12) begin
            stall_left = $urandom_range(2, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Comparison runs at the falling edge after sampling, so it never depends on the
   // order in which the sender and receiver blocks wake at the clock edge.
   always @(negedge clock) begin : compare_units
      result_type got;
      result_type want;
      while (observed_units.size() != 0) begin
         got = observed_units.pop_front();
         if (got.is_end) begin
            end_reports++;
            if (got.status == STATUS_TRUNCATED)
               truncated_ends++;
         end
         if (expected_units.size() == 0) begin
            report_mismatch($sformatf("unexpected result unit=%h end=%b status=%b last=%b",
                                      got.code_unit, got.is_end, got.status,
                                      got.last_of_run));
         end else begin
            want = expected_units.pop_front();
            if (got.code_unit !== want.code_unit)
               report_mismatch($sformatf("result %0d code_unit %h, expected %h",
                                         units_checked, got.code_unit, want.code_unit));
            if (got.is_end !== want.is_end)
               report_mismatch($sformatf("result %0d is_end %b, expected %b",
                                         units_checked, got.is_end, want.is_end));
            if (got.status !== want.status)
               report_mismatch($sformatf("result %0d status %b, expected %b",
                                         units_checked, got.status, want.status));
            if (got.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("result %0d last_of_run %b, expected %b",
                                         units_checked, got.last_of_run,
                                         want.last_of_run));
         end
         units_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == IdleLimit) begin
         $display("timeout: no item moved for %0d cycles", IdleLimit);
         $display("utf8_to_utf16_transcoder regression: fail");
         $finish;
      end
   end

   initial begin : finish_run
      do
         @(negedge clock);
      while (reset || pending_bytes.size() != 0 || req_valid);
      // No more predictions are added now, so the queue only shrinks.
      while (expected_units.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (expected_units.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_units.size()));
      $display("Sent %0d bytes in %0d strings with bursty input and stalled output.",
               bytes_accepted, strings_queued);
      $display("Checked %0d results, %0d end reports (%0d truncated), %0d mismatches.",
               units_checked, end_reports, truncated_ends, mismatch_count);
      if (mismatch_count == 0)
         $display("utf8_to_utf16_transcoder regression: pass");
      else
         $display("utf8_to_utf16_transcoder regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
